// ===== rtl/imbc_pkg.sv =====
// ----------------------------------------------------------------------------
// imbc_pkg
// Types, kind codes and signature matching for the image magic classifier.
// ----------------------------------------------------------------------------
package imbc_pkg;

   localparam int HDR_DEPTH = 12;
   localparam int CNT_W     = $clog2(HDR_DEPTH + 1);
   localparam int PAT_BYTES = 8;

   typedef logic [CNT_W-1:0]                seen_type;
   typedef logic [HDR_DEPTH-1:0][7:0]       hdr_type;
   typedef logic [8*PAT_BYTES-1:0]          pat_type;

   typedef enum logic [3:0] {
      KIND_NONE = 4'd0,
      KIND_PNG  = 4'd1,
      KIND_JPEG = 4'd2,
      KIND_GIF  = 4'd3,
      KIND_WEBP = 4'd4,
      KIND_BMP  = 4'd5,
      KIND_TIFF = 4'd6,
      KIND_ICO  = 4'd7,
      KIND_AVIF = 4'd8,
      KIND_HEIC = 4'd9
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic [3:0] image_kind;
   } rsp_beat_type;

   // Patterns are left-aligned: the first file byte sits in the top byte.
   localparam pat_type SIG_PNG     = 64'h89504E470D0A1A0A;
   localparam pat_type SIG_JPEG    = {24'hFFD8FF, 40'h0};
   localparam pat_type SIG_GIF87   = {48'h474946383761, 16'h0};
   localparam pat_type SIG_GIF89   = {48'h474946383961, 16'h0};
   localparam pat_type SIG_RIFF    = {32'h52494646, 32'h0};
   localparam pat_type SIG_WEBP    = {32'h57454250, 32'h0};
   localparam pat_type SIG_BMP     = {16'h424D, 48'h0};
   localparam pat_type SIG_TIFF_LE = {32'h49492A00, 32'h0};
   localparam pat_type SIG_TIFF_BE = {32'h4D4D002A, 32'h0};
   localparam pat_type SIG_ICO     = {32'h00000100, 32'h0};
   localparam pat_type SIG_FTYP    = {32'h66747970, 32'h0};
   localparam pat_type BR_AVIF     = {32'h61766966, 32'h0};
   localparam pat_type BR_AVIS     = {32'h61766973, 32'h0};
   localparam pat_type BR_HEIC     = {32'h68656963, 32'h0};
   localparam pat_type BR_HEIX     = {32'h68656978, 32'h0};
   localparam pat_type BR_HEVC     = {32'h68657663, 32'h0};
   localparam pat_type BR_HEVX     = {32'h68657678, 32'h0};
   localparam pat_type BR_MIF1     = {32'h6D696631, 32'h0};

   // Bytes off..off+len-1 were seen and equal the pattern.
   function automatic logic hdr_match(hdr_type hdr, seen_type seen, int off,
                                      pat_type pat, int len);
      logic hit;
      hit = (off + len <= HDR_DEPTH) && (off + len <= int'(seen));
      for (int i = 0; i < PAT_BYTES; i++) begin
         if (i < len && off + i < HDR_DEPTH) begin
            if (hdr[off + i] != pat[8*PAT_BYTES-1-8*i -: 8]) begin
               hit = 1'b0;
            end
         end
      end
      return hit;
   endfunction

   function automatic kind_type classify(hdr_type hdr, seen_type seen);
      kind_type kind;
      kind = KIND_NONE;
      if (hdr_match(hdr, seen, 0, SIG_PNG, 8)) begin
         kind = KIND_PNG;
      end else if (hdr_match(hdr, seen, 0, SIG_JPEG, 3)) begin
         kind = KIND_JPEG;
      end else if (hdr_match(hdr, seen, 0, SIG_GIF87, 6) ||
                   hdr_match(hdr, seen, 0, SIG_GIF89, 6)) begin
         kind = KIND_GIF;
      end else if (hdr_match(hdr, seen, 0, SIG_RIFF, 4) &&
                   hdr_match(hdr, seen, 8, SIG_WEBP, 4)) begin
         kind = KIND_WEBP;
      end else if (hdr_match(hdr, seen, 0, SIG_BMP, 2)) begin
         kind = KIND_BMP;
      end else if (hdr_match(hdr, seen, 0, SIG_TIFF_LE, 4) ||
                   hdr_match(hdr, seen, 0, SIG_TIFF_BE, 4)) begin
         kind = KIND_TIFF;
      end else if (hdr_match(hdr, seen, 0, SIG_ICO, 4)) begin
         kind = KIND_ICO;
      end else if (int'(seen) >= HDR_DEPTH && hdr_match(hdr, seen, 4, SIG_FTYP, 4)) begin
         if (hdr_match(hdr, seen, 8, BR_AVIF, 4) || hdr_match(hdr, seen, 8, BR_AVIS, 4)) begin
            kind = KIND_AVIF;
         end else if (hdr_match(hdr, seen, 8, BR_HEIC, 4) ||
                      hdr_match(hdr, seen, 8, BR_HEIX, 4) ||
                      hdr_match(hdr, seen, 8, BR_HEVC, 4) ||
                      hdr_match(hdr, seen, 8, BR_HEVX, 4) ||
                      hdr_match(hdr, seen, 8, BR_MIF1, 4)) begin
            kind = KIND_HEIC;
         end
      end
      return kind;
   endfunction

endpackage

// ===== rtl/imbc_if.sv =====
// ----------------------------------------------------------------------------
// imbc_req_if / imbc_rsp_if
// Valid/ready channels carrying byte beats in and kind beats out.
// ----------------------------------------------------------------------------
interface imbc_req_if;
   import imbc_pkg::*;
   logic         valid;
   logic         ready;
   req_beat_type beat;
   modport source (output valid, output beat, input ready);
   modport sink   (input valid, input beat, output ready);
endinterface

interface imbc_rsp_if;
   import imbc_pkg::*;
   logic         valid;
   logic         ready;
   rsp_beat_type beat;
   modport source (output valid, output beat, input ready);
   modport sink   (input valid, input beat, output ready);
endinterface

// ===== rtl/image_magic_byte_classifier.sv =====
// ----------------------------------------------------------------------------
// image_magic_byte_classifier
// Sorts a file into an image kind from its first twelve bytes.
// ----------------------------------------------------------------------------
// One byte beat is taken per cycle, sustained, whenever the result register is
// empty or being drained in the same cycle; the kind for a file is registered
// and appears on the result channel in the cycle after its final byte is taken.
// With a single result register, a stall on the result side holds the byte side
// only while that register is full. Signature compares work on the header
// registers updated with the incoming byte, so no extra stage is needed.
module image_magic_byte_classifier (
   input  logic             clock,
   input  logic             reset,
   imbc_req_if.sink         req_chan,
   imbc_rsp_if.source       rsp_chan
);
   import imbc_pkg::*;

   hdr_type    hdr_ff, hdr_in;
   seen_type   cnt_ff, cnt_in;
   seen_type   seen_now;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] kind_ff, kind_in;
   logic       req_take;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      hdr_in   = hdr_ff;
      seen_now = cnt_ff;
      if (req_take && int'(cnt_ff) < HDR_DEPTH) begin
         for (int i = 0; i < HDR_DEPTH; i++) begin
            if (cnt_ff == CNT_W'(i)) begin
               hdr_in[i] = req_chan.beat.data_byte;
            end
         end
         seen_now = cnt_ff + seen_type'(1);
      end
      // restart the count once a file ends
      cnt_in = (req_take && req_chan.beat.last_byte) ? '0 : seen_now;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      if (req_take && req_chan.beat.last_byte) begin
         rsp_valid_in = 1'b1;
         kind_in      = classify(hdr_in, seen_now);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hdr_ff  <= hdr_in;
      kind_ff <= kind_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.beat.image_kind = kind_ff;

   a_last_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      req_take && req_chan.beat.last_byte |=> rsp_valid_ff)
      else $error("final byte taken without a result");

   a_last_clears_cnt : assert property (@(posedge clock) disable iff (reset)
      req_take && req_chan.beat.last_byte |=> cnt_ff == '0)
      else $error("byte count not cleared after final byte");

   a_cnt_bounded : assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= HDR_DEPTH)
      else $error("byte count past header depth");

   a_kind_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> kind_ff <= KIND_HEIC)
      else $error("image kind out of range");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !req_take)
      else $error("beat taken while result stalled");

endmodule
